// File: hw/rtl/pte_pkg.sv
// Shared constants, status codes and the reciprocal table for the path tangent estimator.
// No dependencies.
package pte_pkg;

  localparam int RADIUS = 20;
  localparam int WIN = 2 * RADIUS + 1;
  localparam int SLOT_W = $clog2(WIN);
  localparam int SEEN_W = 17;
  localparam logic [SEEN_W-1:0] SEEN_MAX = '1;
  localparam int ACC_W = 42;
  localparam int REC_W = 17;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_ZERO  = 2'd1;
  localparam logic [1:0] ST_SHORT = 2'd2;
  localparam logic [1:0] ST_SAT   = 2'd3;

  // round(65536 / d) for d = 1 .. 2R
  function automatic logic [REC_W-1:0] rec_of(input logic [SLOT_W-1:0] d);
    logic [REC_W-1:0] r;
    case (d)
      6'd1:  r = 17'd65536;
      6'd2:  r = 17'd32768;
      6'd3:  r = 17'd21845;
      6'd4:  r = 17'd16384;
      6'd5:  r = 17'd13107;
      6'd6:  r = 17'd10923;
      6'd7:  r = 17'd9362;
      6'd8:  r = 17'd8192;
      6'd9:  r = 17'd7282;
      6'd10: r = 17'd6554;
      6'd11: r = 17'd5958;
      6'd12: r = 17'd5461;
      6'd13: r = 17'd5041;
      6'd14: r = 17'd4681;
      6'd15: r = 17'd4369;
      6'd16: r = 17'd4096;
      6'd17: r = 17'd3855;
      6'd18: r = 17'd3641;
      6'd19: r = 17'd3449;
      6'd20: r = 17'd3277;
      6'd21: r = 17'd3121;
      6'd22: r = 17'd2979;
      6'd23: r = 17'd2849;
      6'd24: r = 17'd2731;
      6'd25: r = 17'd2621;
      6'd26: r = 17'd2521;
      6'd27: r = 17'd2427;
      6'd28: r = 17'd2341;
      6'd29: r = 17'd2260;
      6'd30: r = 17'd2185;
      6'd31: r = 17'd2114;
      6'd32: r = 17'd2048;
      6'd33: r = 17'd1986;
      6'd34: r = 17'd1928;
      6'd35: r = 17'd1872;
      6'd36: r = 17'd1820;
      6'd37: r = 17'd1771;
      6'd38: r = 17'd1725;
      6'd39: r = 17'd1680;
      6'd40: r = 17'd1638;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// File: hw/rtl/pte_window.sv
// Circular point buffer: slot 0 is the oldest point, slot WIN-1 the newest.
// Depends on pte_pkg.
module pte_window
  import pte_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [31:0]       wr_data,
  input  logic [SLOT_W-1:0] rd_slot,
  output logic [31:0]       rd_data
);

  logic [31:0]       mem [WIN];
  logic [SLOT_W-1:0] wp_r;
  logic [SLOT_W-1:0] wp_nxt;
  logic [SLOT_W:0]   sum;
  logic [SLOT_W-1:0] rd_addr;
  logic [31:0]       rd_data_r;

  assign wp_nxt = (wp_r == SLOT_W'(WIN - 1)) ? '0 : wp_r + 1'b1;
  assign sum = {1'b0, wp_r} + {1'b0, rd_slot};
  assign rd_addr = (sum >= (SLOT_W+1)'(WIN)) ? SLOT_W'(sum - (SLOT_W+1)'(WIN))
                                             : sum[SLOT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
    end else if (wr_en) begin
      wp_r <= wp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wp_r] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: hw/rtl/path_tangent_estimator_top.sv
// Path tangent estimator top level: sequencer, shared multiplier, root and divide steps.
// Depends on pte_pkg and pte_window.
//
//  channel | ports                                             | direction
//  in      | in_valid in_stall in_point_x/_y in_final_point     | item in
//  out     | out_valid out_stall out_point_index out_tangent_x/_y out_status out_run_end | item out
//
// Each tangent fetches the center point, then handles each of the 40 window neighbors with a read,
// x and y products scaled by the reciprocal of the slot distance and accumulation, skipping the
// center; then a zero check, normalizing shifts, the squares, root steps, two divides and the emit
// (a zero sum goes from the check to the emit). An item yields up to R+1 tangents, one after another.
// in_stall is high while tangents are being computed; a held result does not block input.
// rst_n is synchronous; the window contents are not cleared.
module path_tangent_estimator_top
  import pte_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_point_x,
  input  logic [15:0] in_point_y,
  input  logic        in_final_point,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_point_index,
  output logic [15:0] out_tangent_x,
  output logic [15:0] out_tangent_y,
  output logic [1:0]  out_status,
  output logic        out_run_end
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_RDC  = 5'd1;
  localparam logic [4:0] S_LDC  = 5'd2;
  localparam logic [4:0] S_RDJ  = 5'd3;
  localparam logic [4:0] S_MX   = 5'd4;
  localparam logic [4:0] S_MY   = 5'd5;
  localparam logic [4:0] S_AY   = 5'd6;
  localparam logic [4:0] S_CHK  = 5'd7;
  localparam logic [4:0] S_SHR  = 5'd8;
  localparam logic [4:0] S_SHL  = 5'd9;
  localparam logic [4:0] S_SQX  = 5'd10;
  localparam logic [4:0] S_SQY  = 5'd11;
  localparam logic [4:0] S_SQS  = 5'd12;
  localparam logic [4:0] S_ROOT = 5'd13;
  localparam logic [4:0] S_DIV  = 5'd14;
  localparam logic [4:0] S_EMIT = 5'd15;

  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WIN - 1);
  localparam logic [SLOT_W-1:0] SLOT_MID  = SLOT_W'(RADIUS);

  logic [4:0]               state_r;
  logic [SEEN_W-1:0]        seen_r, n_r, n_nxt;
  logic                     short_r, zero_r;
  logic [SLOT_W-1:0]        c_r, last_r, j_r;
  logic [31:0]              pc_r;
  logic signed [16:0]       dy_r;
  logic [REC_W-1:0]         rec_r;
  logic signed [ACC_W-1:0]  acc_x_r, acc_y_r;
  logic signed [63:0]       prod_r;
  logic [ACC_W-2:0]         ax_r, ay_r;
  logic                     nx_r, ny_r;
  logic [63:0]              sq_r, rt_r, b_r;
  logic [47:0]              rem_r, dv_r;
  logic [16:0]              q_r;
  logic [4:0]               cnt_r;
  logic                     comp_r;
  logic [15:0]              tx_r, ty_r;

  logic                     out_valid_r;
  logic [15:0]              out_index_r, out_tx_r, out_ty_r;
  logic [1:0]               out_status_r;
  logic                     out_run_end_r;

  logic                     accept;
  logic [SLOT_W-1:0]        rd_slot;
  logic [31:0]              rd_data;
  logic signed [32:0]       mul_a, mul_b;
  logic signed [65:0]       mul_p;
  logic                     j_lt_c;
  logic [SLOT_W-1:0]        slot_dist;
  logic signed [16:0]       dx, dy;
  logic [63:0]              rb;
  logic                     div_ge;
  logic [47:0]              rem_sub;
  logic [16:0]              q_new;
  logic [15:0]              q_round;
  logic [15:0]              q_clamp;
  logic [15:0]              q_signed;
  logic                     out_load;
  logic [SEEN_W-1:0]        idx;
  logic [ACC_W-2:0]         ax_abs, ay_abs;

  assign accept = (state_r == S_IDLE) && in_valid;
  assign in_stall = (state_r != S_IDLE);
  assign n_nxt = (seen_r == SEEN_MAX) ? seen_r : seen_r + 1'b1;

  assign rd_slot = (state_r == S_RDC) ? c_r : j_r;

  pte_window u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (accept),
    .wr_data ({in_point_y, in_point_x}),
    .rd_slot (rd_slot),
    .rd_data (rd_data)
  );

  assign j_lt_c = (j_r < c_r);
  assign slot_dist = j_lt_c ? (c_r - j_r) : (j_r - c_r);
  assign dx = j_lt_c ? ($signed({pc_r[15], pc_r[15:0]}) - $signed({rd_data[15], rd_data[15:0]}))
                     : ($signed({rd_data[15], rd_data[15:0]}) - $signed({pc_r[15], pc_r[15:0]}));
  assign dy = j_lt_c ? ($signed({pc_r[31], pc_r[31:16]}) - $signed({rd_data[31], rd_data[31:16]}))
                     : ($signed({rd_data[31], rd_data[31:16]}) - $signed({pc_r[31], pc_r[31:16]}));

  always_comb begin
    case (state_r)
      S_MX: begin
        mul_a = 33'(dx);
        mul_b = $signed({16'd0, rec_of(slot_dist)});
      end
      S_MY: begin
        mul_a = 33'(dy_r);
        mul_b = $signed({16'd0, rec_r});
      end
      S_SQX: begin
        mul_a = $signed({2'b00, ax_r[30:0]});
        mul_b = $signed({2'b00, ax_r[30:0]});
      end
      S_SQY: begin
        mul_a = $signed({2'b00, ay_r[30:0]});
        mul_b = $signed({2'b00, ay_r[30:0]});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  assign ax_abs = acc_x_r[ACC_W-1] ? (ACC_W-1)'(-acc_x_r) : acc_x_r[ACC_W-2:0];
  assign ay_abs = acc_y_r[ACC_W-1] ? (ACC_W-1)'(-acc_y_r) : acc_y_r[ACC_W-2:0];

  assign rb = rt_r + b_r;

  assign div_ge = (rem_r >= dv_r);
  assign rem_sub = div_ge ? rem_r - dv_r : rem_r;
  assign q_new = {q_r[15:0], div_ge};
  assign q_round = 16'((18'(q_new) + 18'd1) >> 1);
  assign q_clamp = (q_round > 16'd16384) ? 16'd16384 : q_round;
  assign q_signed = (comp_r ? ny_r : nx_r) ? -q_clamp : q_clamp;

  assign out_load = (state_r == S_EMIT) && (!out_valid_r || !out_stall);
  assign idx = n_r - SEEN_W'(WIN) + SEEN_W'(c_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      seen_r <= '0;
      short_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            n_r <= n_nxt;
            seen_r <= in_final_point ? '0 : n_nxt;
            if (n_nxt < SEEN_W'(WIN)) begin
              if (in_final_point) begin
                short_r <= 1'b1;
                state_r <= S_EMIT;
              end
            end else begin
              short_r <= 1'b0;
              c_r <= (n_nxt == SEEN_W'(WIN)) ? '0 : SLOT_MID;
              last_r <= (n_nxt != SEEN_W'(WIN) && in_final_point) ? SLOT_LAST : SLOT_MID;
              state_r <= S_RDC;
            end
          end
        end
        S_RDC: begin
          acc_x_r <= '0;
          acc_y_r <= '0;
          j_r <= '0;
          state_r <= S_LDC;
        end
        S_LDC: begin
          pc_r <= rd_data;
          state_r <= S_RDJ;
        end
        S_RDJ: begin
          if (j_r == c_r) begin
            if (j_r == SLOT_LAST) begin
              state_r <= S_CHK;
            end else begin
              j_r <= j_r + 1'b1;
            end
          end else begin
            state_r <= S_MX;
          end
        end
        S_MX: begin
          prod_r <= mul_p[63:0];
          dy_r <= dy;
          rec_r <= rec_of(slot_dist);
          state_r <= S_MY;
        end
        S_MY: begin
          acc_x_r <= acc_x_r + ACC_W'(prod_r);
          prod_r <= mul_p[63:0];
          state_r <= S_AY;
        end
        S_AY: begin
          acc_y_r <= acc_y_r + ACC_W'(prod_r);
          if (j_r == SLOT_LAST) begin
            state_r <= S_CHK;
          end else begin
            j_r <= j_r + 1'b1;
            state_r <= S_RDJ;
          end
        end
        S_CHK: begin
          ax_r <= ax_abs;
          ay_r <= ay_abs;
          nx_r <= acc_x_r[ACC_W-1];
          ny_r <= acc_y_r[ACC_W-1];
          if (acc_x_r == '0 && acc_y_r == '0) begin
            zero_r <= 1'b1;
            tx_r <= '0;
            ty_r <= '0;
            state_r <= S_EMIT;
          end else begin
            zero_r <= 1'b0;
            state_r <= S_SHR;
          end
        end
        S_SHR: begin
          if ((ax_r | ay_r) >> 31 != '0) begin
            ax_r <= ax_r >> 1;
            ay_r <= ay_r >> 1;
          end else begin
            state_r <= S_SHL;
          end
        end
        S_SHL: begin
          if ((ax_r | ay_r) >> 30 == '0) begin
            ax_r <= ax_r << 1;
            ay_r <= ay_r << 1;
          end else begin
            state_r <= S_SQX;
          end
        end
        S_SQX: begin
          prod_r <= mul_p[63:0];
          state_r <= S_SQY;
        end
        S_SQY: begin
          sq_r <= prod_r;
          prod_r <= mul_p[63:0];
          state_r <= S_SQS;
        end
        S_SQS: begin
          sq_r <= sq_r + prod_r;
          rt_r <= '0;
          b_r <= 64'd1 << 62;
          state_r <= S_ROOT;
        end
        S_ROOT: begin
          if (sq_r >= rb) begin
            sq_r <= sq_r - rb;
            rt_r <= (rt_r >> 1) + b_r;
          end else begin
            rt_r <= rt_r >> 1;
          end
          b_r <= b_r >> 2;
          if (b_r == 64'd1) begin
            comp_r <= 1'b0;
            cnt_r <= 5'd16;
            q_r <= '0;
            rem_r <= 48'(ax_r[30:0]) << 15;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (dv_r != '0) begin
            rem_r <= rem_sub;
            q_r <= q_new;
            cnt_r <= cnt_r - 1'b1;
            if (cnt_r == '0) begin
              if (!comp_r) begin
                tx_r <= q_signed;
                comp_r <= 1'b1;
                cnt_r <= 5'd16;
                q_r <= '0;
                rem_r <= 48'(ay_r[30:0]) << 15;
              end else begin
                ty_r <= q_signed;
                state_r <= S_EMIT;
              end
            end
          end
        end
        S_EMIT: begin
          if (out_load) begin
            if (short_r || c_r == last_r) begin
              short_r <= 1'b0;
              state_r <= S_IDLE;
            end else begin
              c_r <= c_r + 1'b1;
              state_r <= S_RDC;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // hold the divisor register clear between normalizations
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r <= '0;
    end else if (state_r == S_DIV) begin
      if (dv_r == '0) begin
        dv_r <= 48'(rt_r[31:0]) << 16;
      end else if (cnt_r == '0) begin
        dv_r <= '0;
      end else begin
        dv_r <= dv_r >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (short_r) begin
        out_index_r <= (n_r - 1'b1 > SEEN_W'(16'hFFFF)) ? 16'hFFFF : 16'(n_r - 1'b1);
        out_tx_r <= '0;
        out_ty_r <= '0;
        out_status_r <= ST_SHORT;
        out_run_end_r <= 1'b1;
      end else begin
        out_index_r <= idx[SEEN_W-1] ? 16'hFFFF : idx[15:0];
        out_tx_r <= tx_r;
        out_ty_r <= ty_r;
        out_status_r <= zero_r ? ST_ZERO : (idx[SEEN_W-1] ? ST_SAT : ST_OK);
        out_run_end_r <= (c_r == last_r);
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_point_index = out_index_r;
  assign out_tangent_x = out_tx_r;
  assign out_tangent_y = out_ty_r;
  assign out_status = out_status_r;
  assign out_run_end = out_run_end_r;

endmodule

// File: hw/rtl/pte_checker.sv
// Port-level checks for the path tangent estimator, bound to the top level.
// Depends on pte_pkg and path_tangent_estimator_top.
module pte_checker
  import pte_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_tangent_x,
  input logic [15:0] out_tangent_y,
  input logic [1:0]  out_status,
  input logic        out_run_end
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_tangent_x) && $stable(out_status))
    else $error("result dropped while stalled");

  a_short_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_SHORT |-> out_run_end && out_tangent_x == 16'd0
      && out_tangent_y == 16'd0)
    else $error("short-path item malformed");

  a_zero_tan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_ZERO |-> out_tangent_x == 16'd0 && out_tangent_y == 16'd0)
    else $error("zero-length item has a tangent");

  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_OK || out_status == ST_SAT) |->
      $signed(out_tangent_x) <= 16'sd16384 && $signed(out_tangent_x) >= -16'sd16384
      && (out_tangent_x != 16'd0 || out_tangent_y != 16'd0))
    else $error("tangent out of unit range");

endmodule

bind path_tangent_estimator_top pte_checker u_pte_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_tangent_x (out_tangent_x),
  .out_tangent_y (out_tangent_y),
  .out_status    (out_status),
  .out_run_end   (out_run_end)
);
